@@ design/pkcs1_v15_digest_signature_check_defines.svh @@
// Assertion macros shared by the checker RTL.
`ifndef PKCS1_V15_DIGEST_SIGNATURE_CHECK_DEFINES_SVH
`define PKCS1_V15_DIGEST_SIGNATURE_CHECK_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define PSC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, clocked on clk, off during reset.
`define PSC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ design/pkcs1_sig_pkg.sv @@
package pkcs1_sig_pkg;

	localparam int MaxBlockBytes  = 512;
	localparam int MaxDigestBytes = 64;
	localparam int PosW           = 10;
	localparam int CntW           = 7;
	localparam int AddrW          = $clog2(MaxDigestBytes);
	localparam int PrefixDepth    = 19;
	localparam int HashCount      = 5;

	localparam logic [PosW-1:0] PosMax = {PosW{1'b1}};
	localparam logic [CntW-1:0] CntMax = {CntW{1'b1}};

	localparam logic [2:0] HASH_SHA1   = 3'd0;
	localparam logic [2:0] HASH_SHA256 = 3'd1;
	localparam logic [2:0] HASH_SHA384 = 3'd2;
	localparam logic [2:0] HASH_SHA512 = 3'd3;
	localparam logic [2:0] HASH_MD5    = 3'd4;

	localparam logic REG_MODULUS = 1'b0;
	localparam logic REG_HASH    = 1'b1;

	localparam logic [7:0] BYTE_ZERO = 8'h00;
	localparam logic [7:0] BYTE_ONE  = 8'h01;
	localparam logic [7:0] BYTE_PAD  = 8'hFF;

	localparam logic [PosW-1:0] MOD_RESET = PosW'(256);

	typedef enum logic [2:0] {
		FLT_NONE,
		FLT_HEADER,
		FLT_DIGEST_LEN,
		FLT_MOD_SHORT,
		FLT_PADDING,
		FLT_SEPARATOR,
		FLT_PREFIX,
		FLT_DIGEST
	} fault_t;

	typedef struct packed {
		fault_t            code;
		logic              need_cmp;
		logic [AddrW-1:0]  addr;
		logic              dlen_bad;
		logic              mod_short;
	} layout_t;

	// SHA-1 and MD5 rows are zero-filled past their length
	localparam logic [7:0] DER_PREFIX [HashCount][PrefixDepth] = '{
		'{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2B, 8'h0E, 8'h03, 8'h02,
		  8'h1A, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
		'{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
		'{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40},
		'{8'h30, 8'h20, 8'h30, 8'h0C, 8'h06, 8'h08, 8'h2A, 8'h86, 8'h48, 8'h86,
		  8'hF7, 8'h0D, 8'h02, 8'h05, 8'h05, 8'h00, 8'h04, 8'h10, 8'h00}
	};

	function automatic logic hash_known(input logic [2:0] kind);
		return kind <= HASH_MD5;
	endfunction

	function automatic logic [4:0] prefix_len(input logic [2:0] kind);
		logic [4:0] r;
		case (kind)
			HASH_SHA1:   r = 5'd15;
			HASH_SHA256: r = 5'd19;
			HASH_SHA384: r = 5'd19;
			HASH_SHA512: r = 5'd19;
			HASH_MD5:    r = 5'd18;
			default:     r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [6:0] digest_len(input logic [2:0] kind);
		logic [6:0] r;
		case (kind)
			HASH_SHA1:   r = 7'd20;
			HASH_SHA256: r = 7'd32;
			HASH_SHA384: r = 7'd48;
			HASH_SHA512: r = 7'd64;
			HASH_MD5:    r = 7'd16;
			default:     r = 7'd0;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] prefix_byte(input logic [2:0] kind, input logic [4:0] idx);
		logic [7:0] r;
		r = 8'h00;
		if (hash_known(kind) && idx < 5'(PrefixDepth)) begin
			r = DER_PREFIX[kind][idx];
		end
		return r;
	endfunction

endpackage

@@ design/pkcs1_v15_digest_signature_check.sv @@
// Throughput: one byte (digest or signature) per cycle, except while the last signature byte
// sits in the compare stage and the previous verdict still waits for out_ready. The verdict is
// registered after that compare stage, which the single-port digest RAM with registered read sets.
// Reset: control state cleared, modulus_bytes = 256, hash_kind = SHA-256.
// The digest RAM is not cleared; entries are defined once loaded.
`include "pkcs1_v15_digest_signature_check_defines.svh"

module pkcs1_v15_digest_signature_check (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [pkcs1_sig_pkg::PosW-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [7:0]                     data_byte,
	input  logic                           last,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           signature_ok,
	output logic [2:0]                     fault
);

	logic [pkcs1_sig_pkg::PosW-1:0] modulus_q;
	logic [2:0]                     hash_q;
	logic [pkcs1_sig_pkg::CntW-1:0] count_q;
	logic                           load_open_q;
	logic [pkcs1_sig_pkg::PosW-1:0] pos_q;
	pkcs1_sig_pkg::fault_t          first_q;

	logic [7:0] mem [pkcs1_sig_pkg::MaxDigestBytes];
	logic [7:0] rd_q;

	logic                    valid_s1;
	logic                    sig_s1;
	logic                    last_s1;
	logic [7:0]              byte_s1;
	pkcs1_sig_pkg::fault_t   code_s1;
	logic                    cmp_s1;
	logic                    dlen_bad_s1;
	logic                    mod_short_s1;
	logic                    len_bad_s1;

	logic                    out_valid_q;
	pkcs1_sig_pkg::fault_t   out_fault_q;

	pkcs1_sig_pkg::layout_t         layout;
	logic                           accept;
	logic                           s1_block;
	logic                           s1_done;
	logic [pkcs1_sig_pkg::CntW-1:0] cnt_eff;
	logic [pkcs1_sig_pkg::PosW-1:0] pos_inc;
	pkcs1_sig_pkg::fault_t          byte_fault;
	pkcs1_sig_pkg::fault_t          first_new;
	pkcs1_sig_pkg::fault_t          verdict;

	pkcs1_sig_layout u_layout (
		.position      (pos_q),
		.data_byte     (data_byte),
		.modulus_bytes (modulus_q),
		.hash_kind     (hash_q),
		.digest_count  (count_q),
		.layout        (layout)
	);

	always_comb begin
		s1_block = valid_s1 && sig_s1 && last_s1 && out_valid_q && !out_ready;
		s1_done  = valid_s1 && !s1_block;
		in_ready = !s1_block;
		accept   = in_valid && in_ready;
		cnt_eff  = load_open_q ? count_q : '0;
		pos_inc  = (pos_q < pkcs1_sig_pkg::PosMax) ? pos_q + pkcs1_sig_pkg::PosW'(1) : pos_q;

		if (cmp_s1) begin
			byte_fault = (byte_s1 != rd_q) ? pkcs1_sig_pkg::FLT_DIGEST : pkcs1_sig_pkg::FLT_NONE;
		end else begin
			byte_fault = code_s1;
		end
		first_new = (first_q != pkcs1_sig_pkg::FLT_NONE) ? first_q : byte_fault;

		if (first_new == pkcs1_sig_pkg::FLT_HEADER) verdict = pkcs1_sig_pkg::FLT_HEADER;
		else if (dlen_bad_s1) verdict = pkcs1_sig_pkg::FLT_DIGEST_LEN;
		else if (mod_short_s1) verdict = pkcs1_sig_pkg::FLT_MOD_SHORT;
		else if (first_new != pkcs1_sig_pkg::FLT_NONE) verdict = first_new;
		else if (len_bad_s1) verdict = pkcs1_sig_pkg::FLT_DIGEST;
		else verdict = pkcs1_sig_pkg::FLT_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= pkcs1_sig_pkg::MOD_RESET;
			hash_q    <= pkcs1_sig_pkg::HASH_SHA256;
		end else if (cfg_we) begin
			case (cfg_index)
				pkcs1_sig_pkg::REG_MODULUS: modulus_q <= cfg_data;
				pkcs1_sig_pkg::REG_HASH:    hash_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			load_open_q <= 1'b0;
			pos_q       <= '0;
		end else if (accept) begin
			if (!action) begin
				count_q     <= (cnt_eff < pkcs1_sig_pkg::CntMax) ?
				               cnt_eff + pkcs1_sig_pkg::CntW'(1) : cnt_eff;
				load_open_q <= !last;
				pos_q       <= '0;
			end else begin
				load_open_q <= 1'b0;
				pos_q       <= last ? '0 : pos_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !action && cnt_eff < pkcs1_sig_pkg::CntW'(pkcs1_sig_pkg::MaxDigestBytes)) begin
			mem[cnt_eff[pkcs1_sig_pkg::AddrW-1:0]] <= data_byte;
		end
		if (accept && action) begin
			rd_q <= mem[layout.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!s1_block) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sig_s1       <= action;
			last_s1      <= last;
			byte_s1      <= data_byte;
			code_s1      <= layout.code;
			cmp_s1       <= layout.need_cmp;
			dlen_bad_s1  <= layout.dlen_bad;
			mod_short_s1 <= layout.mod_short;
			len_bad_s1   <= (pos_inc != modulus_q) ||
			                (modulus_q > pkcs1_sig_pkg::PosW'(pkcs1_sig_pkg::MaxBlockBytes));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= pkcs1_sig_pkg::FLT_NONE;
		end else if (s1_done) begin
			if (!sig_s1 || last_s1) first_q <= pkcs1_sig_pkg::FLT_NONE;
			else first_q <= first_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_done && sig_s1 && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done && sig_s1 && last_s1) begin
			out_fault_q <= verdict;
		end
	end

	assign out_valid    = out_valid_q;
	assign fault        = out_fault_q;
	assign signature_ok = (out_fault_q == pkcs1_sig_pkg::FLT_NONE);

	`PSC_ASSERT_NOW(a_stall_cause, !in_ready, valid_s1 && sig_s1 && last_s1 && out_valid_q)
	`PSC_ASSERT_NEXT(a_block_end, accept && action && last, pos_q == '0 && valid_s1)
	`PSC_ASSERT_NEXT(a_stall_holds, s1_block, valid_s1 && sig_s1 && last_s1)
	`PSC_ASSERT_NEXT(a_load_resets_fault, s1_done && !sig_s1, first_q == pkcs1_sig_pkg::FLT_NONE)

endmodule

@@ design/pkcs1_sig_layout.sv @@
module pkcs1_sig_layout (
	input  logic [pkcs1_sig_pkg::PosW-1:0] position,
	input  logic [7:0]                     data_byte,
	input  logic [pkcs1_sig_pkg::PosW-1:0] modulus_bytes,
	input  logic [2:0]                     hash_kind,
	input  logic [pkcs1_sig_pkg::CntW-1:0] digest_count,
	output pkcs1_sig_pkg::layout_t         layout
);

	logic [4:0]                     plen;
	logic [6:0]                     dlen;
	logic [pkcs1_sig_pkg::PosW-1:0] body_len;
	logic [pkcs1_sig_pkg::PosW-1:0] min_len;
	logic [pkcs1_sig_pkg::PosW-1:0] posn;
	logic [pkcs1_sig_pkg::PosW-1:0] digest_start;
	logic [pkcs1_sig_pkg::PosW-1:0] pre_off;
	logic [pkcs1_sig_pkg::PosW-1:0] dig_off;
	logic                           known;

	always_comb begin
		known        = pkcs1_sig_pkg::hash_known(hash_kind);
		plen         = pkcs1_sig_pkg::prefix_len(hash_kind);
		dlen         = pkcs1_sig_pkg::digest_len(hash_kind);
		body_len     = pkcs1_sig_pkg::PosW'(plen) + pkcs1_sig_pkg::PosW'(dlen);
		min_len      = body_len + pkcs1_sig_pkg::PosW'(11);
		posn         = modulus_bytes - body_len;
		digest_start = modulus_bytes - pkcs1_sig_pkg::PosW'(dlen);
		pre_off      = position - posn;
		dig_off      = position - digest_start;

		layout.dlen_bad  = !known || (digest_count != dlen);
		layout.mod_short = known && (modulus_bytes < min_len);
		layout.code      = pkcs1_sig_pkg::FLT_NONE;
		layout.need_cmp  = 1'b0;
		layout.addr      = dig_off[pkcs1_sig_pkg::AddrW-1:0];

		if (position == '0) begin
			if (data_byte != pkcs1_sig_pkg::BYTE_ZERO) layout.code = pkcs1_sig_pkg::FLT_HEADER;
		end else if (position == pkcs1_sig_pkg::PosW'(1)) begin
			if (data_byte != pkcs1_sig_pkg::BYTE_ONE) layout.code = pkcs1_sig_pkg::FLT_HEADER;
		end else if (layout.dlen_bad || layout.mod_short || position >= modulus_bytes) begin
			layout.code = pkcs1_sig_pkg::FLT_NONE;
		end else if (position < posn - pkcs1_sig_pkg::PosW'(1)) begin
			if (data_byte != pkcs1_sig_pkg::BYTE_PAD) layout.code = pkcs1_sig_pkg::FLT_PADDING;
		end else if (position == posn - pkcs1_sig_pkg::PosW'(1)) begin
			if (data_byte != pkcs1_sig_pkg::BYTE_ZERO) layout.code = pkcs1_sig_pkg::FLT_SEPARATOR;
		end else if (position < digest_start) begin
			if (data_byte != pkcs1_sig_pkg::prefix_byte(hash_kind, pre_off[4:0])) begin
				layout.code = pkcs1_sig_pkg::FLT_PREFIX;
			end
		end else begin
			layout.need_cmp = 1'b1;
		end
	end

endmodule

@@ test/pkcs1_v15_digest_signature_check_tb.sv @@
`timescale 1ns / 100ps

module pkcs1_v15_digest_signature_check_tb;

	localparam int DRAIN_LIMIT = 5000;
	localparam int WATCHDOG_NS = 4_000_000;

	// DigestInfo prefixes, zero-filled to a common depth
	localparam logic [7:0] DIGEST_INFO [5][19] = '{
		'{8'h30, 8'h21, 8'h30, 8'h09, 8'h06, 8'h05, 8'h2B, 8'h0E, 8'h03, 8'h02,
		  8'h1A, 8'h05, 8'h00, 8'h04, 8'h14, 8'h00, 8'h00, 8'h00, 8'h00},
		'{8'h30, 8'h31, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h01, 8'h05, 8'h00, 8'h04, 8'h20},
		'{8'h30, 8'h41, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h02, 8'h05, 8'h00, 8'h04, 8'h30},
		'{8'h30, 8'h51, 8'h30, 8'h0d, 8'h06, 8'h09, 8'h60, 8'h86, 8'h48, 8'h01,
		  8'h65, 8'h03, 8'h04, 8'h02, 8'h03, 8'h05, 8'h00, 8'h04, 8'h40},
		'{8'h30, 8'h20, 8'h30, 8'h0C, 8'h06, 8'h08, 8'h2A, 8'h86, 8'h48, 8'h86,
		  8'hF7, 8'h0D, 8'h02, 8'h05, 8'h05, 8'h00, 8'h04, 8'h10, 8'h00}
	};
	localparam int INFO_BYTES [5] = '{15, 19, 19, 19, 18};
	localparam int HASH_BYTES [5] = '{20, 32, 48, 64, 16};

	typedef struct packed {
		logic                  ok;
		pkcs1_sig_pkg::fault_t flt;
	} verdict_t;

	logic                           clk       = 1'b0;
	logic                           arst_n    = 1'b0;
	logic                           cfg_we    = 1'b0;
	logic                           cfg_index = pkcs1_sig_pkg::REG_MODULUS;
	logic [pkcs1_sig_pkg::PosW-1:0] cfg_data  = '0;
	logic                           in_valid  = 1'b0;
	logic                           in_ready;
	logic                           action    = 1'b0;
	logic [7:0]                     data_byte = 8'h00;
	logic                           last      = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic                           signature_ok;
	logic [2:0]                     fault;

	// shadow of the checker state
	logic [pkcs1_sig_pkg::PosW-1:0] mod_bytes_m;
	logic [2:0]                     hash_m;
	logic [7:0]                     digest_mem [pkcs1_sig_pkg::MaxDigestBytes];
	logic [pkcs1_sig_pkg::CntW-1:0] digest_cnt;
	logic                           load_open;
	logic [pkcs1_sig_pkg::PosW-1:0] blk_pos;
	pkcs1_sig_pkg::fault_t          blk_fault;

	verdict_t         pending_verdicts [$];
	int               mismatch_count   = 0;
	int               items_accepted   = 0;
	int               verdicts_checked = 0;
	int               send_idle_pct    = 0;
	int               recv_idle_pct    = 0;

	pkcs1_v15_digest_signature_check i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.data_byte    (data_byte),
		.last         (last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.signature_ok (signature_ok),
		.fault        (fault)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("%0t ns mismatch: %s", $realtime, msg);
	endtask

	function automatic logic digest_len_wrong();
		if (hash_m > pkcs1_sig_pkg::HASH_MD5) return 1'b1;
		return int'(digest_cnt) != HASH_BYTES[hash_m];
	endfunction

	function automatic logic modulus_too_short();
		if (hash_m > pkcs1_sig_pkg::HASH_MD5) return 1'b0;
		return int'(mod_bytes_m) < INFO_BYTES[hash_m] + HASH_BYTES[hash_m] + 11;
	endfunction

	function automatic pkcs1_sig_pkg::fault_t byte_fault(input int p, input logic [7:0] b);
		int plen;
		int dstart;
		if (p == 0) begin
			return (b != pkcs1_sig_pkg::BYTE_ZERO) ?
				pkcs1_sig_pkg::FLT_HEADER : pkcs1_sig_pkg::FLT_NONE;
		end
		if (p == 1) begin
			return (b != pkcs1_sig_pkg::BYTE_ONE) ?
				pkcs1_sig_pkg::FLT_HEADER : pkcs1_sig_pkg::FLT_NONE;
		end
		if (digest_len_wrong() || modulus_too_short() || p >= int'(mod_bytes_m)) begin
			return pkcs1_sig_pkg::FLT_NONE;
		end
		plen = INFO_BYTES[hash_m];
		dstart = int'(mod_bytes_m) - plen - HASH_BYTES[hash_m];
		if (p < dstart - 1) begin
			return (b != pkcs1_sig_pkg::BYTE_PAD) ?
				pkcs1_sig_pkg::FLT_PADDING : pkcs1_sig_pkg::FLT_NONE;
		end
		if (p == dstart - 1) begin
			return (b != pkcs1_sig_pkg::BYTE_ZERO) ?
				pkcs1_sig_pkg::FLT_SEPARATOR : pkcs1_sig_pkg::FLT_NONE;
		end
		if (p < dstart + plen) begin
			return (b != DIGEST_INFO[hash_m][p - dstart]) ?
				pkcs1_sig_pkg::FLT_PREFIX : pkcs1_sig_pkg::FLT_NONE;
		end
		return (b != digest_mem[(p - dstart - plen) % pkcs1_sig_pkg::MaxDigestBytes]) ?
			pkcs1_sig_pkg::FLT_DIGEST : pkcs1_sig_pkg::FLT_NONE;
	endfunction

	task automatic predict_transfer(input logic act, input logic [7:0] b, input logic lst);
		pkcs1_sig_pkg::fault_t f;
		verdict_t              v;
		if (!act) begin
			if (!load_open) begin
				digest_cnt = '0;
				load_open = 1'b1;
			end
			if (digest_cnt < pkcs1_sig_pkg::CntW'(pkcs1_sig_pkg::MaxDigestBytes)) begin
				digest_mem[digest_cnt[pkcs1_sig_pkg::AddrW-1:0]] = b;
			end
			if (digest_cnt < pkcs1_sig_pkg::CntMax) digest_cnt++;
			if (lst) load_open = 1'b0;
			blk_pos = '0;
			blk_fault = pkcs1_sig_pkg::FLT_NONE;
		end else begin
			load_open = 1'b0;
			if (blk_fault == pkcs1_sig_pkg::FLT_NONE) blk_fault = byte_fault(int'(blk_pos), b);
			if (blk_pos < pkcs1_sig_pkg::PosMax) blk_pos++;
			if (lst) begin
				if (blk_fault == pkcs1_sig_pkg::FLT_HEADER) f = pkcs1_sig_pkg::FLT_HEADER;
				else if (digest_len_wrong()) f = pkcs1_sig_pkg::FLT_DIGEST_LEN;
				else if (modulus_too_short()) f = pkcs1_sig_pkg::FLT_MOD_SHORT;
				else if (blk_fault != pkcs1_sig_pkg::FLT_NONE) f = blk_fault;
				else if (blk_pos != mod_bytes_m ||
					int'(mod_bytes_m) > pkcs1_sig_pkg::MaxBlockBytes) f = pkcs1_sig_pkg::FLT_DIGEST;
				else f = pkcs1_sig_pkg::FLT_NONE;
				v.ok = (f == pkcs1_sig_pkg::FLT_NONE);
				v.flt = f;
				pending_verdicts.push_back(v);
				blk_pos = '0;
				blk_fault = pkcs1_sig_pkg::FLT_NONE;
			end
		end
	endtask

	// byte that fits the expected layout at position p under the current setting
	function automatic logic [7:0] layout_byte(input int p);
		int plen;
		int dstart;
		int idx;
		if (p == 0) return pkcs1_sig_pkg::BYTE_ZERO;
		if (p == 1) return pkcs1_sig_pkg::BYTE_ONE;
		if (hash_m > pkcs1_sig_pkg::HASH_MD5 || p >= int'(mod_bytes_m)) return 8'($urandom);
		plen = INFO_BYTES[hash_m];
		dstart = int'(mod_bytes_m) - plen - HASH_BYTES[hash_m];
		if (dstart < 11) return 8'($urandom);
		if (p < dstart - 1) return pkcs1_sig_pkg::BYTE_PAD;
		if (p == dstart - 1) return pkcs1_sig_pkg::BYTE_ZERO;
		if (p < dstart + plen) return DIGEST_INFO[hash_m][p - dstart];
		idx = p - dstart - plen;
		if (idx >= int'(digest_cnt)) return 8'($urandom);
		return digest_mem[idx];
	endfunction

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			verdicts_checked++;
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict ok=%b fault=%0d with none expected",
					signature_ok, fault));
			end else begin
				want = pending_verdicts.pop_front();
				if (signature_ok !== want.ok) begin
					report_mismatch($sformatf("signature_ok %b, expected %b", signature_ok, want.ok));
				end
				if (fault !== want.flt) begin
					report_mismatch($sformatf("fault %0d, expected %0d", fault, want.flt));
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_byte(input logic act, input logic [7:0] b, input logic lst);
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		data_byte <= b;
		last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_accepted++;
		predict_transfer(act, b, lst);
	endtask

	task automatic wait_drained();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (pending_verdicts.size() != 0) begin
			report_mismatch($sformatf("%0d expected verdicts never arrived", pending_verdicts.size()));
			pending_verdicts.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [pkcs1_sig_pkg::PosW-1:0] value);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == pkcs1_sig_pkg::REG_MODULUS) mod_bytes_m = value;
		else hash_m = value[2:0];
	endtask

	task automatic set_mode(input logic [2:0] hk, input int modulus);
		write_reg(pkcs1_sig_pkg::REG_HASH, pkcs1_sig_pkg::PosW'(hk));
		write_reg(pkcs1_sig_pkg::REG_MODULUS, pkcs1_sig_pkg::PosW'(modulus));
	endtask

	task automatic load_digest(input int n, input logic mark_last);
		for (int i = 0; i < n; i++) begin
			send_byte(1'b0, 8'($urandom), mark_last && (i == n - 1));
		end
	endtask

	// bad_pos < 0 leaves the layout intact
	task automatic send_block(input int len, input int bad_pos, input logic mark_last);
		logic [7:0] b;
		for (int p = 0; p < len; p++) begin
			b = layout_byte(p);
			if (p == bad_pos) b = b ^ 8'(1 << $urandom_range(7));
			send_byte(1'b1, b, mark_last && (p == len - 1));
		end
	endtask

	function automatic int min_modulus(input logic [2:0] hk);
		return INFO_BYTES[hk] + HASH_BYTES[hk] + 11;
	endfunction

	task automatic test_reset_state();
		send_block(2, -1, 1'b1);
		load_digest(HASH_BYTES[pkcs1_sig_pkg::HASH_SHA256], 1'b1);
		send_block(4, -1, 1'b1);
	endtask

	task automatic test_hash_kinds();
		for (int k = 0; k <= int'(pkcs1_sig_pkg::HASH_MD5); k++) begin
			set_mode(3'(k), min_modulus(3'(k)));
			load_digest(HASH_BYTES[k], 1'b1);
			send_block(min_modulus(3'(k)), -1, 1'b1);
			write_reg(pkcs1_sig_pkg::REG_MODULUS, pkcs1_sig_pkg::PosW'(min_modulus(3'(k)) - 1));
			send_block(4, -1, 1'b1);
		end
	endtask

	task automatic test_fault_codes();
		int m;
		m = min_modulus(pkcs1_sig_pkg::HASH_SHA1);
		set_mode(pkcs1_sig_pkg::HASH_SHA1, m);
		load_digest(HASH_BYTES[pkcs1_sig_pkg::HASH_SHA1], 1'b1);
		// each block but the last ends on its bad byte
		send_block(1, 0, 1'b1);
		send_block(2, 1, 1'b1);
		send_block(3, 2, 1'b1);
		send_block(11, 10, 1'b1);
		send_block(12, 11, 1'b1);
		send_block(27, 26, 1'b1);
		send_block(m, m - 1, 1'b1);
		send_block(m + 4, -1, 1'b1);
		// header fault outranks a bad digest length
		load_digest(HASH_BYTES[pkcs1_sig_pkg::HASH_SHA1] - 1, 1'b1);
		send_block(2, 0, 1'b1);
		send_block(4, -1, 1'b1);
	endtask

	task automatic test_config_extremes();
		set_mode(pkcs1_sig_pkg::HASH_SHA1, 0);
		load_digest(HASH_BYTES[pkcs1_sig_pkg::HASH_SHA1], 1'b1);
		send_block(3, -1, 1'b1);
		send_block(2, 0, 1'b1);
		write_reg(pkcs1_sig_pkg::REG_HASH, pkcs1_sig_pkg::PosW'(7));
		send_block(4, -1, 1'b1);
		write_reg(pkcs1_sig_pkg::REG_HASH, pkcs1_sig_pkg::PosW'(5));
		send_block(4, -1, 1'b1);
		set_mode(pkcs1_sig_pkg::HASH_SHA1, pkcs1_sig_pkg::MaxBlockBytes + 1);
		send_block(pkcs1_sig_pkg::MaxBlockBytes + 1, -1, 1'b1);
		write_reg(pkcs1_sig_pkg::REG_MODULUS, pkcs1_sig_pkg::PosMax);
		send_block(min_modulus(pkcs1_sig_pkg::HASH_SHA1), -1, 1'b1);
	endtask

	task automatic test_digest_sequencing();
		set_mode(pkcs1_sig_pkg::HASH_SHA512, min_modulus(pkcs1_sig_pkg::HASH_SHA512));
		load_digest(130, 1'b1);
		send_block(4, -1, 1'b1);
		set_mode(pkcs1_sig_pkg::HASH_MD5, min_modulus(pkcs1_sig_pkg::HASH_MD5));
		// digest transfer in the middle of a block drops the block
		load_digest(HASH_BYTES[pkcs1_sig_pkg::HASH_MD5], 1'b1);
		send_block(30, -1, 1'b0);
		load_digest(HASH_BYTES[pkcs1_sig_pkg::HASH_MD5], 1'b1);
		send_block(min_modulus(pkcs1_sig_pkg::HASH_MD5), -1, 1'b1);
		// signature transfer closes an unterminated load
		load_digest(HASH_BYTES[pkcs1_sig_pkg::HASH_MD5], 1'b0);
		send_block(min_modulus(pkcs1_sig_pkg::HASH_MD5), -1, 1'b1);
		load_digest(10, 1'b1);
		send_block(2, -1, 1'b1);
	endtask

	task automatic test_random_traffic(input int sp, input int rp, input int item_goal,
		input int verdict_goal);
		int         item_base;
		int         verdict_base;
		int         pick;
		int         m;
		int         blen;
		int         dlen;
		int         delta;
		logic [2:0] hk;
		logic       first;
		send_idle_pct = sp;
		recv_idle_pct = rp;
		item_base = items_accepted;
		verdict_base = verdicts_checked;
		first = 1'b1;
		while (items_accepted - item_base < item_goal ||
			verdicts_checked - verdict_base < verdict_goal) begin
			if (first || $urandom_range(3) == 0) begin
				first = 1'b0;
				hk = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4, 0));
				m = (hk <= pkcs1_sig_pkg::HASH_MD5) ? min_modulus(hk) : 20;
				pick = $urandom_range(9);
				if (pick == 0) m = $urandom_range(int'(pkcs1_sig_pkg::PosMax), 0);
				else if (pick == 1) m = m - $urandom_range(6, 1);
				else m = m + $urandom_range(30, 0);
				if (m < 0) m = 0;
				set_mode(hk, m);
				dlen = (hk <= pkcs1_sig_pkg::HASH_MD5) ? HASH_BYTES[hk] : $urandom_range(70, 1);
				pick = $urandom_range(19);
				if (pick < 2) dlen = dlen + $urandom_range(3, 1) - (pick == 0 ? 6 : 0);
				if (dlen < 1) dlen = 1;
				load_digest(dlen, 1'b1);
			end
			blen = int'(mod_bytes_m);
			if (blen > 140) blen = $urandom_range(20, 1);
			if (blen == 0) blen = $urandom_range(4, 1);
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_block(blen, -1, 1'b1);
			end else if (pick < 75) begin
				send_block(blen, $urandom_range(blen - 1), 1'b1);
			end else if (pick < 85) begin
				delta = $urandom_range(3, 1);
				if ($urandom_range(1) == 0) delta = -delta;
				send_block((blen + delta < 1) ? 1 : blen + delta, -1, 1'b1);
			end else if (pick < 92) begin
				send_block($urandom_range(blen, 1), -1, 1'b0);
				load_digest((hash_m <= pkcs1_sig_pkg::HASH_MD5) ? HASH_BYTES[hash_m] : 20, 1'b1);
				send_block(blen, -1, 1'b1);
			end else begin
				repeat ($urandom_range(12, 3)) begin
					send_byte(1'($urandom), 8'($urandom), $urandom_range(4) == 0);
				end
			end
			if ($urandom_range(19) == 0) wait_drained();
		end
	endtask

	initial begin
		mod_bytes_m = pkcs1_sig_pkg::MOD_RESET;
		hash_m = pkcs1_sig_pkg::HASH_SHA256;
		foreach (digest_mem[i]) digest_mem[i] = 8'h00;
		digest_cnt = '0;
		load_open = 1'b0;
		blk_pos = '0;
		blk_fault = pkcs1_sig_pkg::FLT_NONE;
		send_idle_pct = 15;
		recv_idle_pct = 49;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_hash_kinds();
		test_fault_codes();
		test_config_extremes();
		test_digest_sequencing();
		test_random_traffic(15, 49, 20, 2);
		test_random_traffic(49, 15, 60, 3);
		test_random_traffic(0, 0, 60, 3);
		wait_drained();
		if (mismatch_count == 0) begin
			$display("pkcs1_v15_digest_signature_check verification clean");
		end else begin
			$display("pkcs1_v15_digest_signature_check verification failed");
		end
		$finish;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("pkcs1_v15_digest_signature_check verification failed");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/pkcs1_sig_pkg.sv
design/pkcs1_sig_layout.sv
design/pkcs1_v15_digest_signature_check.sv
test/pkcs1_v15_digest_signature_check_tb.sv
